/* sv/tpt_pkg.sv */
// ---------------------------------------------------------------------------
// tpt_pkg
// Shared types, codes and helpers of the tracker pattern transcoder.
// ---------------------------------------------------------------------------
package tpt_pkg;

    // Item operations
    localparam logic [1:0] OP_DATA      = 2'd0;
    localparam logic [1:0] OP_HEADER    = 2'd1;
    localparam logic [1:0] OP_EMPTY_ROW = 2'd2;

    // Parse phases
    localparam logic [2:0] PH_CHANNEL = 3'd0;
    localparam logic [2:0] PH_MASK    = 3'd1;
    localparam logic [2:0] PH_NOTE    = 3'd2;
    localparam logic [2:0] PH_INSTR   = 3'd3;
    localparam logic [2:0] PH_VCMD    = 3'd4;
    localparam logic [2:0] PH_CMD     = 3'd5;
    localparam logic [2:0] PH_PARAM   = 3'd6;

    localparam logic [7:0] ROW_MARK = 8'hFF;

    // What an accepted word asks of the controller
    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_HEADER,
        KIND_EMPTY_ROW,
        KIND_ROW_END,
        KIND_MASK_LOOKUP
    } kind_t;

    // Source of the word loaded into the output register
    typedef enum logic [2:0] {
        OSEL_HEADER,
        OSEL_ZERO,
        OSEL_ZERO_LAST,
        OSEL_MARK,
        OSEL_PRESENCE,
        OSEL_DATA
    } osel_t;

    typedef struct packed {
        logic  accept;
        logic  load_out;
        osel_t out_sel;
        logic  mask_finish;
        logic  row_clear;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  fill_zero;
        logic  data_last;
    } sts_t;

    function automatic logic field_needed(input logic [2:0] p, input logic [7:0] m);
        logic r;
        case (p) inside
            PH_NOTE:          r = m[4];
            PH_INSTR:         r = m[5];
            PH_VCMD:          r = m[6];
            PH_CMD, PH_PARAM: r = m[7];
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    // First field phase at or after p that the mask asks for, else channel
    function automatic logic [2:0] next_phase(input logic [2:0] p, input logic [7:0] m);
        logic [2:0] r;
        logic       found;
        r     = PH_CHANNEL;
        found = 1'b0;
        for (int q = 2; q <= 6; q++) begin
            if (!found && 3'(q) >= p && field_needed(3'(q), m)) begin
                r     = 3'(q);
                found = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* sv/tpt_ctrl.sv */
// ---------------------------------------------------------------------------
// tpt_ctrl
// Controller: sequences item acceptance, mask lookups and output words.
// ---------------------------------------------------------------------------
module tpt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tpt_pkg::sts_t sts,
    output tpt_pkg::cmd_t cmd
);
    import tpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEADER,
        S_EMPTY0,
        S_EMPTY1,
        S_MASK_RD,
        S_ROW_MARK,
        S_ROW_PRES,
        S_ROW_DATA
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd.accept      = 1'b0;
        cmd.load_out    = 1'b0;
        cmd.out_sel     = OSEL_HEADER;
        cmd.mask_finish = 1'b0;
        cmd.row_clear   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    unique case (sts.kind)
                        KIND_HEADER:      state_next = S_HEADER;
                        KIND_EMPTY_ROW:   state_next = S_EMPTY0;
                        KIND_ROW_END:     state_next = S_ROW_MARK;
                        KIND_MASK_LOOKUP: state_next = S_MASK_RD;
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_HEADER: begin
                cmd.out_sel  = OSEL_HEADER;
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_EMPTY0: begin
                cmd.out_sel  = OSEL_ZERO;
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_EMPTY1;
                end
            end
            S_EMPTY1: begin
                cmd.out_sel  = OSEL_ZERO_LAST;
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_MASK_RD: begin
                cmd.mask_finish = 1'b1;
                state_next      = S_IDLE;
            end
            S_ROW_MARK: begin
                cmd.out_sel  = OSEL_MARK;
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    state_next = S_ROW_PRES;
                end
            end
            S_ROW_PRES: begin
                cmd.out_sel  = OSEL_PRESENCE;
                cmd.load_out = sts.out_free;
                if (sts.out_free) begin
                    if (sts.fill_zero) begin
                        cmd.row_clear = 1'b1;
                        state_next    = S_IDLE;
                    end else begin
                        state_next = S_ROW_DATA;
                    end
                end
            end
            S_ROW_DATA: begin
                cmd.out_sel  = OSEL_DATA;
                cmd.load_out = sts.out_free;
                if (sts.out_free && sts.data_last) begin
                    cmd.row_clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/tpt_datapath.sv */
// ---------------------------------------------------------------------------
// tpt_datapath
// Datapath: parse state, channel mask memory, row buffer and output register.
// ---------------------------------------------------------------------------
module tpt_datapath #(
    parameter int ROW_BUFFER_BYTES = 48,
    parameter int MASK_CHANNELS    = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    s_operation,
    input  logic [7:0]    s_data_byte,
    input  logic [8:0]    s_row_count,
    input  tpt_pkg::cmd_t cmd,
    output tpt_pkg::sts_t sts,
    input  logic          m_ready,
    output logic          m_valid,
    output logic [7:0]    m_out_byte,
    output logic          m_last,
    output logic          m_pattern_done,
    output logic          m_overflow
);
    import tpt_pkg::*;

    localparam int FW = $clog2(ROW_BUFFER_BYTES + 1);
    localparam int AW = $clog2(ROW_BUFFER_BYTES);
    localparam int MW = $clog2(MASK_CHANNELS);

    logic [2:0]    phase_reg, phase_next;
    logic [5:0]    chan_reg, chan_next;
    logic [7:0]    cur_mask_reg, cur_mask_next;
    logic [7:0]    presence_reg, presence_next;
    logic [8:0]    rows_reg, rows_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          overflow_reg, overflow_next;
    logic          row_done_reg, row_done_next;
    logic [7:0]    hdr_byte_reg, hdr_byte_next;
    logic [FW-1:0] rd_idx_reg, rd_idx_next;
    logic          mask_rd_ok_reg;
    logic [7:0]    mask_rd_reg;
    logic [7:0]    buf_rd_reg;
    logic [MASK_CHANNELS-1:0] mask_valid_reg;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_out_byte_reg, m_out_byte_next;
    logic          m_last_reg, m_last_next;
    logic          m_done_reg, m_done_next;
    logic          m_overflow_reg, m_overflow_next;

    logic [7:0] row_buf  [ROW_BUFFER_BYTES];
    logic [7:0] mask_mem [MASK_CHANNELS];

    logic [5:0]    in_chan;
    logic [7:0]    pres_bit;
    logic [7:0]    swapped;
    logic [7:0]    new_mask;
    logic [7:0]    lookup_mask;
    logic          rows_zero;
    logic          in_chan_ok;
    logic          cur_chan_ok;
    logic [FW-1:0] rd_idx_inc;
    logic          out_free;
    kind_t         kind;

    logic          push_en;
    logic [7:0]    push_val;
    logic          buf_wr;
    logic          buf_rd_en;
    logic [AW-1:0] buf_rd_addr;
    logic          mask_wr;
    logic          mask_rd_en;
    logic          fill_clear;

    assign in_chan     = 6'(s_data_byte - 8'd1);
    assign pres_bit    = (in_chan[5:3] == 3'd0) ? (8'd1 << in_chan[2:0]) : 8'd0;
    assign swapped     = {s_data_byte[3:0], s_data_byte[7:4]};
    assign new_mask    = {swapped[7:4], swapped[3:0] | swapped[7:4]};
    assign lookup_mask = mask_rd_ok_reg ? mask_rd_reg : 8'd0;
    assign rows_zero   = (rows_reg == 9'd0);
    assign in_chan_ok  = ({1'b0, in_chan} < 7'(MASK_CHANNELS));
    assign cur_chan_ok = ({1'b0, chan_reg} < 7'(MASK_CHANNELS));
    assign rd_idx_inc  = rd_idx_reg + FW'(1);
    assign out_free    = !m_valid_reg || m_ready;

    // Classify the word at the input
    always_comb begin
        kind = KIND_PASS;
        if (s_operation == OP_HEADER) begin
            kind = KIND_HEADER;
        end else if (s_operation == OP_EMPTY_ROW && !rows_zero) begin
            kind = KIND_EMPTY_ROW;
        end else if (s_operation == OP_DATA && !rows_zero && phase_reg == PH_CHANNEL) begin
            if (s_data_byte == 8'd0) begin
                kind = KIND_ROW_END;
            end else if (!s_data_byte[7]) begin
                kind = KIND_MASK_LOOKUP;
            end
        end
    end

    assign sts.kind      = kind;
    assign sts.out_free  = out_free;
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.data_last = (rd_idx_inc == fill_reg);

    always_comb begin
        phase_next    = phase_reg;
        chan_next     = chan_reg;
        cur_mask_next = cur_mask_reg;
        presence_next = presence_reg;
        rows_next     = rows_reg;
        fill_next     = fill_reg;
        overflow_next = overflow_reg;
        row_done_next = row_done_reg;
        hdr_byte_next = hdr_byte_reg;
        rd_idx_next   = rd_idx_reg;
        push_en       = 1'b0;
        push_val      = s_data_byte;
        buf_wr        = 1'b0;
        buf_rd_en     = 1'b0;
        buf_rd_addr   = '0;
        mask_wr       = 1'b0;
        mask_rd_en    = 1'b0;
        fill_clear    = 1'b0;

        if (cmd.accept) begin
            case (kind) inside
                KIND_HEADER: begin
                    rows_next     = s_row_count;
                    phase_next    = PH_CHANNEL;
                    presence_next = 8'd0;
                    fill_clear    = 1'b1;
                    hdr_byte_next = s_row_count[7:0] - 8'd1;
                end
                KIND_EMPTY_ROW, KIND_ROW_END: begin
                    rows_next     = rows_reg - 9'd1;
                    row_done_next = (rows_reg == 9'd1);
                end
                KIND_MASK_LOOKUP: begin
                    chan_next     = in_chan;
                    presence_next = presence_reg | pres_bit;
                    mask_rd_en    = 1'b1;
                end
                default: begin
                    if (s_operation == OP_DATA && !rows_zero) begin
                        if (phase_reg == PH_CHANNEL) begin
                            // channel byte with a mask byte to follow
                            chan_next     = in_chan;
                            presence_next = presence_reg | pres_bit;
                            phase_next    = PH_MASK;
                        end else if (phase_reg == PH_MASK) begin
                            cur_mask_next = new_mask;
                            mask_wr       = cur_chan_ok;
                            push_en       = 1'b1;
                            push_val      = new_mask;
                            phase_next    = next_phase(PH_NOTE, new_mask);
                        end else if (phase_reg > PH_PARAM) begin
                            phase_next = PH_CHANNEL;
                        end else begin
                            push_en    = 1'b1;
                            phase_next = next_phase(phase_reg + 3'd1, cur_mask_reg);
                        end
                    end
                end
            endcase
        end

        if (cmd.mask_finish) begin
            cur_mask_next = lookup_mask;
            push_en       = 1'b1;
            push_val      = lookup_mask;
            phase_next    = next_phase(PH_NOTE, lookup_mask);
        end

        // Drop a byte that does not fit and latch the overflow flag
        if (push_en) begin
            if (fill_reg < FW'(ROW_BUFFER_BYTES)) begin
                buf_wr    = 1'b1;
                fill_next = fill_reg + FW'(1);
            end else begin
                overflow_next = 1'b1;
            end
        end

        if (cmd.row_clear) begin
            fill_clear    = 1'b1;
            presence_next = 8'd0;
        end
        if (fill_clear) begin
            fill_next = '0;
        end

        // Prefetch the row buffer one word ahead of the output register
        if (cmd.load_out && cmd.out_sel == OSEL_PRESENCE) begin
            rd_idx_next = '0;
            buf_rd_en   = 1'b1;
            buf_rd_addr = '0;
        end else if (cmd.load_out && cmd.out_sel == OSEL_DATA) begin
            rd_idx_next = rd_idx_inc;
            buf_rd_en   = (rd_idx_inc < FW'(ROW_BUFFER_BYTES));
            buf_rd_addr = rd_idx_inc[AW-1:0];
        end
    end

    always_comb begin
        m_out_byte_next = m_out_byte_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        m_overflow_next = m_overflow_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next    = 1'b1;
            m_overflow_next = overflow_reg;
            case (cmd.out_sel)
                OSEL_HEADER: begin
                    m_out_byte_next = hdr_byte_reg;
                    m_last_next     = 1'b1;
                    m_done_next     = 1'b0;
                end
                OSEL_ZERO: begin
                    m_out_byte_next = 8'd0;
                    m_last_next     = 1'b0;
                    m_done_next     = 1'b0;
                end
                OSEL_ZERO_LAST: begin
                    m_out_byte_next = 8'd0;
                    m_last_next     = 1'b1;
                    m_done_next     = row_done_reg;
                end
                OSEL_MARK: begin
                    m_out_byte_next = ROW_MARK;
                    m_last_next     = 1'b0;
                    m_done_next     = 1'b0;
                end
                OSEL_PRESENCE: begin
                    m_out_byte_next = presence_reg;
                    m_last_next     = (fill_reg == '0);
                    m_done_next     = (fill_reg == '0) && row_done_reg;
                end
                default: begin
                    m_out_byte_next = buf_rd_reg;
                    m_last_next     = (rd_idx_inc == fill_reg);
                    m_done_next     = (rd_idx_inc == fill_reg) && row_done_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_CHANNEL;
            chan_reg       <= '0;
            cur_mask_reg   <= '0;
            presence_reg   <= '0;
            rows_reg       <= '0;
            fill_reg       <= '0;
            overflow_reg   <= 1'b0;
            row_done_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            mask_rd_ok_reg <= 1'b0;
            mask_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            chan_reg     <= chan_next;
            cur_mask_reg <= cur_mask_next;
            presence_reg <= presence_next;
            rows_reg     <= rows_next;
            fill_reg     <= fill_next;
            overflow_reg <= overflow_next;
            row_done_reg <= row_done_next;
            rd_idx_reg   <= rd_idx_next;
            m_valid_reg  <= m_valid_next;
            if (mask_rd_en) begin
                mask_rd_ok_reg <= in_chan_ok && mask_valid_reg[in_chan[MW-1:0]];
            end
            if (mask_wr) begin
                mask_valid_reg[chan_reg[MW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hdr_byte_reg   <= hdr_byte_next;
        m_out_byte_reg <= m_out_byte_next;
        m_last_reg     <= m_last_next;
        m_done_reg     <= m_done_next;
        m_overflow_reg <= m_overflow_next;
    end

    always_ff @(posedge aclk) begin
        if (buf_wr) begin
            row_buf[fill_reg[AW-1:0]] <= push_val;
        end
        if (buf_rd_en) begin
            buf_rd_reg <= row_buf[buf_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mask_wr) begin
            mask_mem[chan_reg[MW-1:0]] <= new_mask;
        end
        if (mask_rd_en) begin
            mask_rd_reg <= mask_mem[in_chan[MW-1:0]];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_last         = m_last_reg;
    assign m_pattern_done = m_done_reg;
    assign m_overflow     = m_overflow_reg;

endmodule

/* sv/tracker_pattern_transcoder.sv */
// A header or empty-row word is taken in S_IDLE, then its words go through the output register.
// A row end gives 0xFF, the presence mask, then one buffered byte a cycle unless m_ready stalls.
// Words with no output stay in S_IDLE; a channel byte with no mask byte passes S_MASK_RD.
// Throughput: one word in flight at a time; a row end drains 2 + fill words through the
// single output register, so the row drain and the mask memory read port set the rate.
// Reset: synchronous, active low; mask memory valid bits clear at once, no clearing pass.
// ---------------------------------------------------------------------------
// tracker_pattern_transcoder
// Transcodes packed tracker pattern bytes into a row-grouped byte stream.
// ---------------------------------------------------------------------------
module tracker_pattern_transcoder #(
    parameter int ROW_BUFFER_BYTES = 48,
    parameter int MASK_CHANNELS    = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_data_byte,
    input  logic [8:0] s_row_count,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_pattern_done,
    output logic       m_overflow
);
    import tpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tpt_datapath #(
        .ROW_BUFFER_BYTES (ROW_BUFFER_BYTES),
        .MASK_CHANNELS    (MASK_CHANNELS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_operation    (s_operation),
        .s_data_byte    (s_data_byte),
        .s_row_count    (s_row_count),
        .cmd            (cmd),
        .sts            (sts),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last),
        .m_pattern_done (m_pattern_done),
        .m_overflow     (m_overflow)
    );

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("output register loaded while a word is still waiting");

    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pattern_done) |-> m_last)
        else $error("pattern done flagged on a word that is not last");

    a_busy_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && sts.kind != KIND_PASS) |=> !s_ready)
        else $error("input taken again before the previous word finished");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |=> m_overflow)
        else $error("overflow flag cleared without reset");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the tracker pattern transcoder: a directed opening,
// then random patterns with random sender gaps and receiver stalls. Every
// accepted input word updates a bit-exact model of the parser and row buffer,
// and every output word is checked against the oldest expected word.
// ---------------------------------------------------------------------------
module tb;
    import tpt_pkg::*;

    localparam int         ROW_CAP       = 48;
    localparam int         MASK_DEPTH    = 64;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS  = 200;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_LIMIT   = 100000;
    localparam int         REPORT_LIMIT  = 40;

    typedef struct packed {
        logic [7:0] out_val;
        logic       last;
        logic       done;
        logic       ovf;
    } pattern_word_t;

    // Parser, row buffer and expected output words of the transcoder
    class row_stream_scoreboard;
        logic [2:0]    phase;
        logic [5:0]    chan;
        logic [7:0]    active_mask;
        logic [7:0]    mask_mem [MASK_DEPTH];
        logic [7:0]    present_bits;
        logic [8:0]    rows_remaining;
        logic [7:0]    row_bytes [ROW_CAP];
        int            row_len;
        logic          ovf_sticky;
        pattern_word_t expected_words [$];
        int            errors;

        function new();
            phase          = PH_CHANNEL;
            chan           = '0;
            active_mask    = '0;
            present_bits   = '0;
            rows_remaining = '0;
            row_len        = 0;
            ovf_sticky     = 1'b0;
            errors         = 0;
            foreach (mask_mem[i]) mask_mem[i] = '0;
            foreach (row_bytes[i]) row_bytes[i] = '0;
        endfunction

        // First field phase at or after start that the mask asks for
        function logic [2:0] next_field(int start, logic [7:0] m);
            logic need;
            for (int q = start; q <= int'(PH_PARAM); q++) begin
                case (3'(q))
                    PH_NOTE:  need = m[4];
                    PH_INSTR: need = m[5];
                    PH_VCMD:  need = m[6];
                    default:  need = m[7];
                endcase
                if (need) return 3'(q);
            end
            return PH_CHANNEL;
        endfunction

        function void expect_word(logic [7:0] v, logic l, logic d);
            pattern_word_t w;
            w = '{out_val: v, last: l, done: d, ovf: ovf_sticky};
            expected_words.insert(expected_words.size(), w);
        endfunction

        // Drop the byte once the row buffer is full
        function void stash(logic [7:0] v);
            if (row_len < ROW_CAP) begin
                row_bytes[row_len] = v;
                row_len++;
            end else begin
                ovf_sticky = 1'b1;
            end
        endfunction

        // Returns 1 when the word had any effect
        function bit note_word(logic [1:0] op, logic [7:0] b, logic [8:0] rc);
            logic [7:0] m;
            logic       last_row;
            case (op)
                OP_HEADER: begin
                    rows_remaining = rc;
                    phase          = PH_CHANNEL;
                    present_bits   = '0;
                    row_len        = 0;
                    expect_word(8'(rc - 9'd1), 1'b1, 1'b0);
                    return 1;
                end
                OP_EMPTY_ROW: begin
                    if (rows_remaining == 0) return 0;
                    rows_remaining--;
                    expect_word(8'h00, 1'b0, 1'b0);
                    expect_word(8'h00, 1'b1, rows_remaining == 0);
                    return 1;
                end
                OP_DATA: begin
                    if (rows_remaining == 0) return 0;
                end
                default: return 0;
            endcase

            if (phase == PH_CHANNEL) begin
                if (b == 8'h00) begin
                    rows_remaining--;
                    last_row = (rows_remaining == 0);
                    expect_word(ROW_MARK, 1'b0, 1'b0);
                    expect_word(present_bits, row_len == 0, row_len == 0 && last_row);
                    for (int i = 0; i < row_len; i++)
                        expect_word(row_bytes[i], i + 1 == row_len, i + 1 == row_len && last_row);
                    row_len      = 0;
                    present_bits = '0;
                end else begin
                    chan = 6'(b - 8'd1);
                    if (chan < 6'd8) present_bits[chan[2:0]] = 1'b1;
                    if (b[7]) begin
                        phase = PH_MASK;
                    end else begin
                        active_mask = mask_mem[chan];
                        stash(active_mask);
                        phase = next_field(PH_NOTE, active_mask);
                    end
                end
            end else if (phase == PH_MASK) begin
                // swap nibbles, then fold the high nibble into the low one
                m           = {b[3:0], b[7:4]};
                m[3:0]      = m[3:0] | m[7:4];
                active_mask = m;
                mask_mem[chan] = m;
                stash(m);
                phase = next_field(PH_NOTE, m);
            end else begin
                stash(b);
                phase = next_field(int'(phase) + 1, active_mask);
            end
            return 1;
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %02h, actual %02h",
                             $time, name, exp_v, act_v);
            end
        endfunction

        function void check_word(logic [7:0] v, logic l, logic d, logic o);
            pattern_word_t e;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected word, expected none, actual %02h last %0b",
                             $time, v, l);
                return;
            end
            e = expected_words.pop_front();
            compare_field("out_byte", e.out_val, v);
            compare_field("last", 8'(e.last), 8'(l));
            compare_field("pattern_done", 8'(e.done), 8'(d));
            compare_field("overflow", 8'(e.ovf), 8'(o));
        endfunction
    endclass

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation    = OP_DATA;
    logic [7:0] s_data_byte    = 8'h00;
    logic [8:0] s_row_count    = 9'd0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       m_pattern_done;
    logic       m_overflow;

    row_stream_scoreboard rows_sb;
    int                   counted_words = 0;
    int                   burst_left    = 0;
    bit                   hold_req      = 1'b0;

    tracker_pattern_transcoder #(
        .ROW_BUFFER_BYTES(ROW_CAP),
        .MASK_CHANNELS   (MASK_DEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_data_byte   (s_data_byte),
        .s_row_count   (s_row_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_pattern_done(m_pattern_done),
        .m_overflow    (m_overflow)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            rows_sb.check_word(m_out_byte, m_last, m_pattern_done, m_overflow);
    end

    // Receiver stalls follow a pattern that changes after a random span; long hold on request
    initial begin : receiver
        int pct;
        int span;
        pct  = 100;
        span = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    span = $urandom_range(16, 80);
                    case ($urandom_range(0, 3))
                        0:       pct = 100;
                        1:       pct = 70;
                        2:       pct = 35;
                        default: pct = 10;
                    endcase
                end
                span--;
                m_ready <= ($urandom_range(1, 100) <= pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Sender works in bursts with random gaps in between
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_word(logic [1:0] op, logic [7:0] b, logic [8:0] rc);
        pace();
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data_byte <= b;
        s_row_count <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (rows_sb.note_word(op, b, rc)) counted_words++;
    endtask

    task automatic send_noise();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        send_word(op, 8'($urandom), (op == OP_HEADER) ? 9'($urandom_range(0, 256))
                                                       : 9'($urandom));
    endtask

    // One row: channel entries with their mask and field words, then the row end
    task automatic send_row(int entries, bit full);
        logic [7:0] b;
        int         ch;
        for (int e = 0; e < entries; e++) begin
            ch = $urandom_range(0, 7);
            if (full)
                b = 8'h80 | 8'(ch + 1);
            else if ($urandom_range(0, 3) == 0)
                b = 8'($urandom_range(1, 255));
            else
                b = 8'(ch + 1) | ($urandom_range(0, 1) ? 8'h80 : 8'h00)
                               | (($urandom_range(0, 3) == 0) ? 8'h40 : 8'h00);
            send_word(OP_DATA, b, 9'($urandom));
            while (rows_sb.phase != PH_CHANNEL && rows_sb.rows_remaining != 0) begin
                if ($urandom_range(0, 39) == 0) send_noise();
                if (rows_sb.phase == PH_MASK && full)
                    b = {4'($urandom), 4'hF};
                else
                    b = 8'($urandom);
                send_word(OP_DATA, b, 9'($urandom));
            end
        end
        send_word(OP_DATA, 8'h00, 9'($urandom));
    endtask

    task automatic send_pattern(bit stress);
        int rows;
        int rows_sent;
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 6);
        send_word(OP_HEADER, 8'($urandom), 9'(rows));
        rows_sent = (rows <= 8) ? rows : $urandom_range(1, 4);
        for (int r = 0; r < rows_sent; r++) begin
            if ($urandom_range(0, 14) == 0) send_noise();
            if (stress && r < 2)
                // exactly full buffer, then one that overflows
                send_row((r == 0) ? 8 : 10, 1'b1);
            else begin
                case ($urandom_range(0, 9))
                    0:       send_word(OP_EMPTY_ROW, 8'($urandom), 9'($urandom));
                    1:       send_row($urandom_range(6, 8), 1'b1);
                    default: send_row($urandom_range(0, 4), 1'b0);
                endcase
            end
        end
        // words past the last row are ignored
        if (rows_sent == rows && $urandom_range(0, 2) == 0)
            send_word(OP_DATA, 8'($urandom), 9'($urandom));
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (rows_sb.expected_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int start_count;
        int idx;
        rows_sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // before any header: ignored
        send_word(OP_DATA, 8'h81, 9'd0);
        send_word(OP_EMPTY_ROW, 8'h00, 9'd0);
        send_word(OP_UNUSED, 8'hFF, 9'h1FF);
        // zero row count
        send_word(OP_HEADER, 8'h00, 9'd0);
        send_word(OP_HEADER, 8'h00, 9'd2);
        // channel 0 with full mask, all five fields
        send_word(OP_DATA, 8'h81, 9'd0);
        send_word(OP_DATA, 8'hFF, 9'd0);
        send_word(OP_DATA, 8'h00, 9'd0);
        send_word(OP_DATA, 8'hFF, 9'd0);
        send_word(OP_DATA, 8'h55, 9'd0);
        send_word(OP_DATA, 8'hAA, 9'd0);
        send_word(OP_DATA, 8'h80, 9'd0);
        // channel 7 from stored mask, channel 0 via wrap with empty mask
        send_word(OP_DATA, 8'h48, 9'd0);
        send_word(OP_DATA, 8'hC1, 9'd0);
        send_word(OP_DATA, 8'h00, 9'd0);
        send_word(OP_DATA, 8'h00, 9'd0);
        send_word(OP_EMPTY_ROW, 8'hFF, 9'h1FF);
        send_word(OP_EMPTY_ROW, 8'h00, 9'd0);
        send_word(OP_HEADER, 8'hFF, 9'd256);
        send_word(OP_DATA, 8'h82, 9'd0);
        send_word(OP_DATA, 8'h0A, 9'd0);
        send_word(OP_DATA, 8'h12, 9'd0);
        send_word(OP_DATA, 8'h34, 9'd0);
        send_word(OP_DATA, 8'h56, 9'd0);
        send_word(OP_DATA, 8'h00, 9'd0);

        start_count = counted_words;
        idx         = 0;
        while (counted_words - start_count < RANDOM_ITEMS || idx < 2) begin
            if (idx == 0) wait_drained();
            if (idx == 1) hold_req = 1'b1;
            send_pattern(idx == 1);
            idx++;
        end

        wait_drained();
        if (rows_sb.expected_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived, expected %02h, actual none",
                     $time, rows_sb.expected_words.size(),
                     rows_sb.expected_words[0].out_val);
            rows_sb.errors++;
        end
        if (rows_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
